@@ rtl/core/elx_pkg.sv @@
// Shared types and constants of the 8-bit load executor.
// Used by elx_front, elx_back, elx_resq and the top level; depends on nothing.
package elx_pkg;

  // Data memory size in address bits (memory aliases on the low bits).
  localparam int MEM_ADDR_BITS = 16;

  // Register file: A, B, C, D, E, H, L.
  localparam int NUM_REGS = 7;
  localparam int REG_AW   = 3;

  // Decoupling queue between front and back.
  localparam int UQ_DEPTH = 2;
  localparam int UQ_AW    = $clog2(UQ_DEPTH);
  localparam int UQ_CW    = UQ_AW + 1;

  // Result queue on the output side.
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = RQ_AW + 1;

  // High page base for the LDH forms.
  localparam logic [7:0] HIGH_PAGE_HI = 8'hFF;

  // Instruction cycle counts.
  localparam logic [4:0] CYC_NONE = 5'd0;
  localparam logic [4:0] CYC_4    = 5'd4;
  localparam logic [4:0] CYC_8    = 5'd8;
  localparam logic [4:0] CYC_12   = 5'd12;
  localparam logic [4:0] CYC_16   = 5'd16;

  // Opcodes decoded by value.
  localparam logic [7:0] OP_HALT    = 8'h76;
  localparam logic [7:0] OP_LDH_ST  = 8'hE0;
  localparam logic [7:0] OP_LDH_LD  = 8'hF0;
  localparam logic [7:0] OP_LDC_ST  = 8'hE2;
  localparam logic [7:0] OP_LDC_LD  = 8'hF2;
  localparam logic [7:0] OP_ABS_ST  = 8'hEA;
  localparam logic [7:0] OP_ABS_LD  = 8'hFA;

  // Operand field codes (bits 5..3 and 2..0 of the opcode).
  localparam logic [2:0] OPR_B   = 3'd0;
  localparam logic [2:0] OPR_C   = 3'd1;
  localparam logic [2:0] OPR_D   = 3'd2;
  localparam logic [2:0] OPR_E   = 3'd3;
  localparam logic [2:0] OPR_H   = 3'd4;
  localparam logic [2:0] OPR_L   = 3'd5;
  localparam logic [2:0] OPR_MEM = 3'd6;

  // Low three opcode bits of the LD r,d8 and indirect-A groups.
  localparam logic [2:0] GRP_IMM = 3'd6;
  localparam logic [2:0] GRP_IND = 3'd2;

  // Pair select of the indirect-A group (opcode bits 5..4).
  localparam logic [1:0] SEL_BC  = 2'd0;
  localparam logic [1:0] SEL_DE  = 2'd1;
  localparam logic [1:0] SEL_HLI = 2'd2;

  typedef enum logic [REG_AW-1:0] {
    R_A, R_B, R_C, R_D, R_E, R_H, R_L
  } reg_e;

  typedef enum logic [2:0] {
    K_UNSUP, K_MOVE, K_IMM, K_LOAD, K_STORE
  } kind_e;

  typedef enum logic [2:0] {
    AM_NONE, AM_HL, AM_BC, AM_DE, AM_HIGH_IMM, AM_HIGH_C, AM_ABS
  } amode_e;

  typedef enum logic [1:0] {
    HS_NONE, HS_INC, HS_DEC
  } hlstep_e;

  // Decoded instruction handed from front to back.
  typedef struct packed {
    kind_e       kind;
    reg_e        dst;
    reg_e        src;
    logic        store_imm;
    amode_e      amode;
    hlstep_e     hl_step;
    logic [4:0]  cycles;
    logic [7:0]  imm_low;
    logic [7:0]  imm_high;
  } uop_t;

  // One finished result.
  typedef struct packed {
    logic [4:0]                   cycles;
    logic                         unsupported;
    logic                         mem_written;
    logic [15:0]                  bus_addr;
    logic [7:0]                   bus_data;
    logic [NUM_REGS-1:0][7:0]     regs;
  } res_t;

endpackage

@@ rtl/core/eight_bit_load_executor.sv @@
// Path: elx_front queue, elx_back second stage, result queue. Throughput: one
// instruction per cycle while the result queue has room and no clear runs, set
// by the single data memory port (one read or write per instruction) with load
// data forwarded to the next one. Reset: registers clear at once; the data
// memory is then cleared one byte a cycle over 65536 addresses; full stays high.
module eight_bit_load_executor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  imm_low_i,
  input  logic [7:0]  imm_high_i,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  cycles_o,
  output logic        unsupported_o,
  output logic        mem_written_o,
  output logic [15:0] bus_addr_o,
  output logic [7:0]  bus_data_o,
  output logic [7:0]  reg_a_o,
  output logic [7:0]  reg_b_o,
  output logic [7:0]  reg_c_o,
  output logic [7:0]  reg_d_o,
  output logic [7:0]  reg_e_o,
  output logic [7:0]  reg_h_o,
  output logic [7:0]  reg_l_o
);
  import elx_pkg::*;

  uop_t uop;
  logic uop_valid;
  logic uop_ready;
  logic room;
  logic busy;
  logic res_push;
  res_t res_in;
  res_t res_out;

  // Front end: request intake and decode.
  elx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .hold_i      (busy),
    .opcode_i    (opcode_i),
    .imm_low_i   (imm_low_i),
    .imm_high_i  (imm_high_i),
    .uop_valid_o (uop_valid),
    .uop_o       (uop),
    .uop_ready_i (uop_ready)
  );

  // Back end: execution against registers and memory.
  elx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_valid_i (uop_valid),
    .uop_i       (uop),
    .uop_ready_o (uop_ready),
    .room_i      (room),
    .busy_o      (busy),
    .push_o      (res_push),
    .res_o       (res_in)
  );

  // Result queue toward the consumer.
  elx_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .res_i  (res_in),
    .room_o (room),
    .empty  (empty),
    .pop    (pop),
    .res_o  (res_out)
  );

  assign cycles_o      = res_out.cycles;
  assign unsupported_o = res_out.unsupported;
  assign mem_written_o = res_out.mem_written;
  assign bus_addr_o    = res_out.bus_addr;
  assign bus_data_o    = res_out.bus_data;
  assign reg_a_o       = res_out.regs[R_A];
  assign reg_b_o       = res_out.regs[R_B];
  assign reg_c_o       = res_out.regs[R_C];
  assign reg_d_o       = res_out.regs[R_D];
  assign reg_e_o       = res_out.regs[R_E];
  assign reg_h_o       = res_out.regs[R_H];
  assign reg_l_o       = res_out.regs[R_L];

endmodule

@@ rtl/core/elx_front.sv @@
// Front end: accepts instruction requests, decodes them and queues the decoded form.
// Depends on elx_pkg.
module elx_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic            hold_i,
  input  logic [7:0]      opcode_i,
  input  logic [7:0]      imm_low_i,
  input  logic [7:0]      imm_high_i,
  output logic            uop_valid_o,
  output elx_pkg::uop_t   uop_o,
  input  logic            uop_ready_i
);
  import elx_pkg::*;

  // Map an operand code to a register; the memory code is handled by the caller.
  function automatic reg_e code_reg(input logic [2:0] code);
    reg_e r;
    begin
      case (code)
        OPR_B:   r = R_B;
        OPR_C:   r = R_C;
        OPR_D:   r = R_D;
        OPR_E:   r = R_E;
        OPR_H:   r = R_H;
        OPR_L:   r = R_L;
        default: r = R_A;
      endcase
      return r;
    end
  endfunction

  // Classify one opcode of the load group.
  function automatic uop_t decode(input logic [7:0] op, input logic [7:0] lo,
                                  input logic [7:0] hi);
    uop_t u;
    begin
      u           = '0;
      u.kind      = K_UNSUP;
      u.dst       = R_A;
      u.src       = R_A;
      u.amode     = AM_NONE;
      u.hl_step   = HS_NONE;
      u.cycles    = CYC_NONE;
      u.imm_low   = lo;
      u.imm_high  = hi;
      if (op inside {[8'h40:8'h7F]}) begin
        if (op != OP_HALT) begin
          u.dst = code_reg(op[5:3]);
          u.src = code_reg(op[2:0]);
          if (op[2:0] == OPR_MEM) begin
            u.kind   = K_LOAD;
            u.amode  = AM_HL;
            u.cycles = CYC_8;
          end else if (op[5:3] == OPR_MEM) begin
            u.kind   = K_STORE;
            u.amode  = AM_HL;
            u.cycles = CYC_8;
          end else begin
            u.kind   = K_MOVE;
            u.cycles = CYC_4;
          end
        end
      end else if (op < 8'h40 && op[2:0] == GRP_IMM) begin
        if (op[5:3] == OPR_MEM) begin
          u.kind      = K_STORE;
          u.store_imm = 1'b1;
          u.amode     = AM_HL;
          u.cycles    = CYC_12;
        end else begin
          u.kind   = K_IMM;
          u.dst    = code_reg(op[5:3]);
          u.cycles = CYC_8;
        end
      end else if (op < 8'h40 && op[2:0] == GRP_IND) begin
        u.kind   = op[3] ? K_LOAD : K_STORE;
        u.cycles = CYC_8;
        case (op[5:4])
          SEL_BC:  u.amode = AM_BC;
          SEL_DE:  u.amode = AM_DE;
          default: u.amode = AM_HL;
        endcase
        case (op[5:4])
          SEL_BC:  u.hl_step = HS_NONE;
          SEL_DE:  u.hl_step = HS_NONE;
          SEL_HLI: u.hl_step = HS_INC;
          default: u.hl_step = HS_DEC;
        endcase
      end else if (op inside {OP_LDH_ST, OP_LDH_LD}) begin
        u.kind   = op[4] ? K_LOAD : K_STORE;
        u.amode  = AM_HIGH_IMM;
        u.cycles = CYC_12;
      end else if (op inside {OP_LDC_ST, OP_LDC_LD}) begin
        u.kind   = op[4] ? K_LOAD : K_STORE;
        u.amode  = AM_HIGH_C;
        u.cycles = CYC_8;
      end else if (op inside {OP_ABS_ST, OP_ABS_LD}) begin
        u.kind   = op[4] ? K_LOAD : K_STORE;
        u.amode  = AM_ABS;
        u.cycles = CYC_16;
      end
      return u;
    end
  endfunction

  uop_t             q_q [UQ_DEPTH];
  logic [UQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [UQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [UQ_CW-1:0] count_q, count_d;
  logic             push_ok;
  logic             pop_ok;

  // Handshake: the queue refuses requests while full or while the back end holds.
  assign full        = (count_q == UQ_CW'(UQ_DEPTH)) || hold_i;
  assign push_ok     = push && !full;
  assign uop_valid_o = (count_q != '0);
  assign pop_ok      = uop_valid_o && uop_ready_i;
  assign uop_o       = q_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = wr_ptr_q + UQ_AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = rd_ptr_q + UQ_AW'(1);
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + UQ_CW'(1);
    end else if (!push_ok && pop_ok) begin
      count_d = count_q - UQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Decoded entries are written as they arrive.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_q[wr_ptr_q] <= decode(opcode_i, imm_low_i, imm_high_i);
    end
  end

endmodule

@@ rtl/core/elx_resq.sv @@
// Result queue: holds finished results until the consumer pops them.
// Depends on elx_pkg.
module elx_resq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  elx_pkg::res_t   res_i,
  output logic            room_o,
  output logic            empty,
  input  logic            pop,
  output elx_pkg::res_t   res_o
);
  import elx_pkg::*;

  res_t             q_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [RQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [RQ_CW-1:0] count_q, count_d;
  logic             pop_ok;

  // Room for one more result beyond the one arriving now.
  assign room_o = (count_q + RQ_CW'(push_i)) < RQ_CW'(RQ_DEPTH);
  assign empty  = (count_q == '0);
  assign pop_ok = pop && !empty;
  assign res_o  = q_q[rd_ptr_q];

  // Pointer and fill count update; a push is always granted space upstream.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + RQ_AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = rd_ptr_q + RQ_AW'(1);
    end
    if (push_i && !pop_ok) begin
      count_d = count_q + RQ_CW'(1);
    end else if (!push_i && pop_ok) begin
      count_d = count_q - RQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

@@ rtl/core/elx_back.sv @@
// Back end: register file, data memory with clearing pass, and instruction execution.
// Depends on elx_pkg.
module elx_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            uop_valid_i,
  input  elx_pkg::uop_t   uop_i,
  output logic            uop_ready_o,
  input  logic            room_i,
  output logic            busy_o,
  output logic            push_o,
  output elx_pkg::res_t   res_o
);
  import elx_pkg::*;

  logic [7:0]                mem_q [2**MEM_ADDR_BITS];
  logic [NUM_REGS-1:0][7:0]  reg_q, reg_d;
  logic [NUM_REGS-1:0][7:0]  cur;
  logic [7:0]                rdata_q;

  logic [MEM_ADDR_BITS-1:0]  clr_addr_q;
  logic                      clr_busy_q;

  logic                      s2_valid_q;
  logic                      s2_load_q;
  reg_e                      s2_dst_q;
  logic [4:0]                s2_cycles_q;
  logic                      s2_unsup_q;
  logic                      s2_wrote_q;
  logic [15:0]               s2_addr_q;
  logic [7:0]                s2_data_q;

  logic                      issue;
  logic                      pend;
  logic [15:0]               hl;
  logic [15:0]               addr;
  logic [7:0]                wdata;
  logic [MEM_ADDR_BITS-1:0]  mem_idx;
  logic                      do_store;
  logic                      do_load;

  // Issue one instruction a cycle once the memory is cleared and the result fits.
  assign issue       = uop_valid_i && room_i && !clr_busy_q;
  assign uop_ready_o = issue;
  assign busy_o      = clr_busy_q;
  assign do_store    = issue && (uop_i.kind == K_STORE);
  assign do_load     = issue && (uop_i.kind == K_LOAD);

  // Register view with the previous load's data forwarded from the read register.
  assign pend = s2_valid_q && s2_load_q;
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      cur[i] = (pend && s2_dst_q == reg_e'(REG_AW'(i))) ? rdata_q : reg_q[i];
    end
  end

  // Address generation.
  assign hl = {cur[R_H], cur[R_L]};
  always_comb begin
    case (uop_i.amode)
      AM_HL:       addr = hl;
      AM_BC:       addr = {cur[R_B], cur[R_C]};
      AM_DE:       addr = {cur[R_D], cur[R_E]};
      AM_HIGH_IMM: addr = {HIGH_PAGE_HI, uop_i.imm_low};
      AM_HIGH_C:   addr = {HIGH_PAGE_HI, cur[R_C]};
      AM_ABS:      addr = {uop_i.imm_high, uop_i.imm_low};
      default:     addr = '0;
    endcase
  end
  assign mem_idx = addr[MEM_ADDR_BITS-1:0];
  assign wdata   = uop_i.store_imm ? uop_i.imm_low : cur[uop_i.src];

  // Register writes: the pending load commits first, then the issuing instruction.
  always_comb begin
    reg_d = reg_q;
    if (pend) begin
      reg_d[s2_dst_q] = rdata_q;
    end
    if (issue) begin
      case (uop_i.kind)
        K_MOVE:  reg_d[uop_i.dst] = cur[uop_i.src];
        K_IMM:   reg_d[uop_i.dst] = uop_i.imm_low;
        default: ;
      endcase
      case (uop_i.hl_step)
        HS_INC:  {reg_d[R_H], reg_d[R_L]} = hl + 16'd1;
        HS_DEC:  {reg_d[R_H], reg_d[R_L]} = hl - 16'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q <= '0;
    end else begin
      reg_q <= reg_d;
    end
  end

  // Clearing pass over the data memory after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + MEM_ADDR_BITS'(1);
      if (clr_addr_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Data memory: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (do_store) begin
      mem_q[mem_idx] <= wdata;
    end
    if (do_load) begin
      rdata_q <= mem_q[mem_idx];
    end
  end

  // Second stage: the result is completed once load data is back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_load_q   <= (uop_i.kind == K_LOAD);
      s2_dst_q    <= uop_i.dst;
      s2_cycles_q <= uop_i.cycles;
      s2_unsup_q  <= (uop_i.kind == K_UNSUP);
      s2_wrote_q  <= (uop_i.kind == K_STORE);
      s2_addr_q   <= addr;
      s2_data_q   <= (uop_i.kind == K_STORE) ? wdata : 8'd0;
    end
  end

  // Result assembly; the forwarded view holds the registers after this instruction.
  assign push_o = s2_valid_q;
  always_comb begin
    res_o.cycles      = s2_cycles_q;
    res_o.unsupported = s2_unsup_q;
    res_o.mem_written = s2_wrote_q;
    res_o.bus_addr    = s2_addr_q;
    res_o.bus_data    = s2_load_q ? rdata_q : s2_data_q;
    res_o.regs        = cur;
  end

endmodule
